>>> rtl/lpfr_pkg.sv
`default_nettype none

package lpfr_pkg;

   localparam int unsigned NUM_CH     = 3;
   localparam int unsigned LVL_W      = 8;
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned DELTA_W    = LVL_W + 1;
   localparam int unsigned CH_W       = 2;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CNT_W      = 5;

   localparam logic [LVL_W-1:0]      FULL_LEVEL     = 8'd255;
   localparam logic [TIME_W-1:0]     RESET_INTERVAL = 16'd75;
   localparam logic [NUM_CH-1:0]     RESET_INVERT   = 3'b111;

   localparam logic [CSR_IDX_W-1:0]  CSR_INVERT_MASK = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_STEP_INTVL  = 1'd1;

   localparam logic                  MODE_FADE = 1'b0;
   localparam logic                  MODE_TICK = 1'b1;

   // divider pass lengths: time / interval, then range / divisions
   localparam logic [CNT_W-1:0]      DIV_STEPS_TIME  = 5'd16;
   localparam logic [CNT_W-1:0]      DIV_STEPS_RANGE = 5'd8;

   typedef struct packed {
      logic latch;
      logic tick;
      logic div_time;
      logic div_range;
      logic load_fade;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic fade_ok;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/lpfr_if.sv
`default_nettype none

interface lpfr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [lpfr_pkg::CH_W-1:0]      channel;
   logic [lpfr_pkg::LVL_W-1:0]     target_level;
   logic [lpfr_pkg::TIME_W-1:0]    fade_time_ms;

   modport source (output valid, mode, channel, target_level, fade_time_ms, input ready);
   modport sink   (input valid, mode, channel, target_level, fade_time_ms, output ready);
endinterface

interface lpfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpfr_pkg::LVL_W-1:0]     red_level;
   logic [lpfr_pkg::LVL_W-1:0]     green_level;
   logic [lpfr_pkg::LVL_W-1:0]     blue_level;
   logic [lpfr_pkg::NUM_CH-1:0]    fading_mask;

   modport source (output valid, red_level, green_level, blue_level, fading_mask,
                   input ready);
   modport sink   (input valid, red_level, green_level, blue_level, fading_mask,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/lpfr_div.sv
`default_nettype none

module lpfr_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [lpfr_pkg::CNT_W-1:0]     steps,
   input  wire logic [lpfr_pkg::TIME_W-1:0]    dividend,
   input  wire logic [lpfr_pkg::TIME_W-1:0]    divisor,
   output logic                                done,
   output logic [lpfr_pkg::TIME_W-1:0]         quotient,
   output logic [lpfr_pkg::TIME_W-1:0]         remainder
);

   logic [lpfr_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                         done_ff, done_in;
   logic [lpfr_pkg::TIME_W-1:0]  quo_ff, quo_in;
   logic [lpfr_pkg::TIME_W-1:0]  rem_ff, rem_in;
   logic [lpfr_pkg::TIME_W-1:0]  dsr_ff, dsr_in;
   logic [lpfr_pkg::TIME_W:0]    shifted;
   logic [lpfr_pkg::TIME_W:0]    trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[lpfr_pkg::TIME_W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      count_in = count_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         count_in = steps;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == lpfr_pkg::CNT_W'(1));
         if (!trial[lpfr_pkg::TIME_W]) begin
            rem_in = trial[lpfr_pkg::TIME_W-1:0];
            quo_in = {quo_ff[lpfr_pkg::TIME_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[lpfr_pkg::TIME_W-1:0];
            quo_in = {quo_ff[lpfr_pkg::TIME_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> rtl/lpfr_dp.sv
`default_nettype none

module lpfr_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [lpfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lpfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_mode,
   input  wire logic [lpfr_pkg::CH_W-1:0]         req_channel,
   input  wire logic [lpfr_pkg::LVL_W-1:0]        req_target,
   input  wire logic [lpfr_pkg::TIME_W-1:0]       req_time,
   input  wire lpfr_pkg::cmd_type                 cmd,
   output lpfr_pkg::sts_type                      sts,
   output logic [lpfr_pkg::LVL_W-1:0]             rsp_red,
   output logic [lpfr_pkg::LVL_W-1:0]             rsp_green,
   output logic [lpfr_pkg::LVL_W-1:0]             rsp_blue,
   output logic [lpfr_pkg::NUM_CH-1:0]            rsp_mask
);

   localparam int unsigned N  = lpfr_pkg::NUM_CH;
   localparam int unsigned LW = lpfr_pkg::LVL_W;
   localparam int unsigned TW = lpfr_pkg::TIME_W;
   localparam int unsigned DW = lpfr_pkg::DELTA_W;

   logic [N-1:0]      invert_ff;
   logic [TW-1:0]     interval_ff;

   logic              mode_ff;
   logic [lpfr_pkg::CH_W-1:0] chan_ff;
   logic [LW-1:0]     target_ff;
   logic [TW-1:0]     time_ff;

   logic [LW-1:0]     level_ff [N];
   logic [LW-1:0]     final_ff [N];
   logic [DW-1:0]     delta_ff [N];
   logic [TW-1:0]     steps_ff [N];
   logic [LW-1:0]     level_in [N];
   logic [TW-1:0]     steps_in [N];

   logic [TW-1:0]     pend_steps_ff;

   logic [LW-1:0]     out_red_ff, out_green_ff, out_blue_ff;
   logic [N-1:0]      out_mask_ff, mask_now;

   logic              chan_ok;
   logic [lpfr_pkg::CH_W-1:0] ch_idx;
   logic              inv;
   logic [LW-1:0]     cur, cur_b, mag, fin_new;
   logic              neg;
   logic [TW-1:0]     iv;

   logic              div_start, div_done;
   logic [lpfr_pkg::CNT_W-1:0] div_steps;
   logic [TW-1:0]     div_dividend, div_divisor, div_quo, div_rem;
   logic [TW-1:0]     divisions;
   logic [TW:0]       steps_sum;
   logic [DW-1:0]     mag_q, delta_new;

   always_comb begin
      chan_ok = (chan_ff < lpfr_pkg::CH_W'(N));
      ch_idx  = chan_ok ? chan_ff : '0;
      inv     = invert_ff[ch_idx];
      cur     = level_ff[ch_idx];
      cur_b   = inv ? (lpfr_pkg::FULL_LEVEL - cur) : cur;
      neg     = (target_ff < cur_b);
      mag     = neg ? (cur_b - target_ff) : (target_ff - cur_b);
      fin_new = inv ? (lpfr_pkg::FULL_LEVEL - target_ff) : target_ff;
      iv      = (interval_ff == '0) ? TW'(1) : interval_ff;

      divisions = (div_quo == '0) ? TW'(1) : div_quo;
      steps_sum = {1'b0, div_quo} + {{TW{1'b0}}, (div_rem != '0)};

      div_start    = cmd.div_time | cmd.div_range;
      div_steps    = cmd.div_time ? lpfr_pkg::DIV_STEPS_TIME : lpfr_pkg::DIV_STEPS_RANGE;
      div_dividend = cmd.div_time ? time_ff : {mag, {(TW-LW){1'b0}}};
      div_divisor  = cmd.div_time ? iv : divisions;

      mag_q     = {1'b0, div_quo[LW-1:0]};
      delta_new = (neg ^ inv) ? (~mag_q + 1'b1) : mag_q;

      sts.is_tick  = (mode_ff == lpfr_pkg::MODE_TICK);
      sts.fade_ok  = chan_ok && (mag != '0);
      sts.div_done = div_done;
   end

   lpfr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .steps     (div_steps),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // per-channel ramp step
   always_comb begin
      logic signed [LW+1:0] sum;
      logic signed [LW+1:0] fin;
      logic signed [LW+1:0] nxt;
      for (int c = 0; c < N; c++) begin
         sum = $signed({2'b00, level_ff[c]}) + $signed({delta_ff[c][DW-1], delta_ff[c]});
         fin = $signed({2'b00, final_ff[c]});
         nxt = sum;
         if (!delta_ff[c][DW-1] && (delta_ff[c] != '0) && (sum > fin)) nxt = fin;
         if (delta_ff[c][DW-1] && (sum < fin)) nxt = fin;
         if (steps_ff[c] == TW'(1)) nxt = fin;
         if (nxt < 0) nxt = '0;
         if (nxt > $signed({2'b00, lpfr_pkg::FULL_LEVEL})) nxt = {2'b00, lpfr_pkg::FULL_LEVEL};
         level_in[c] = level_ff[c];
         steps_in[c] = steps_ff[c];
         if (steps_ff[c] != '0) begin
            level_in[c] = nxt[LW-1:0];
            steps_in[c] = steps_ff[c] - 1'b1;
         end
         mask_now[c] = (steps_ff[c] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff   <= lpfr_pkg::RESET_INVERT;
         interval_ff <= lpfr_pkg::RESET_INTERVAL;
         for (int c = 0; c < N; c++) begin
            level_ff[c] <= lpfr_pkg::FULL_LEVEL;
            final_ff[c] <= lpfr_pkg::FULL_LEVEL;
            delta_ff[c] <= '0;
            steps_ff[c] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               lpfr_pkg::CSR_INVERT_MASK: invert_ff   <= csr_wdata[N-1:0];
               lpfr_pkg::CSR_STEP_INTVL:  interval_ff <= csr_wdata[TW-1:0];
               default: ;
            endcase
         end
         if (cmd.tick) begin
            for (int c = 0; c < N; c++) begin
               level_ff[c] <= level_in[c];
               steps_ff[c] <= steps_in[c];
            end
         end
         if (cmd.load_fade) begin
            delta_ff[ch_idx] <= delta_new;
            final_ff[ch_idx] <= fin_new;
            steps_ff[ch_idx] <= pend_steps_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= req_mode;
         chan_ff   <= req_channel;
         target_ff <= req_target;
         time_ff   <= req_time;
      end
      if (cmd.div_range) pend_steps_ff <= steps_sum[TW-1:0];
      if (cmd.load_rsp) begin
         out_red_ff   <= level_ff[0];
         out_green_ff <= level_ff[1];
         out_blue_ff  <= level_ff[2];
         out_mask_ff  <= mask_now;
      end
   end

   assign rsp_red   = out_red_ff;
   assign rsp_green = out_green_ff;
   assign rsp_blue  = out_blue_ff;
   assign rsp_mask  = out_mask_ff;

endmodule

`default_nettype wire

>>> rtl/lpfr_ctrl.sv
`default_nettype none

module lpfr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire lpfr_pkg::sts_type  sts,
   output lpfr_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_TIME,
      ST_DIV_RANGE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch = req_valid;
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.is_tick) begin
               cmd.tick = 1'b1;
               state_in = ST_DONE;
            end else if (sts.fade_ok) begin
               cmd.div_time = 1'b1;
               state_in     = ST_DIV_TIME;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_TIME: begin
            if (sts.div_done) begin
               cmd.div_range = 1'b1;
               state_in      = ST_DIV_RANGE;
            end
         end
         ST_DIV_RANGE: begin
            if (sts.div_done) begin
               cmd.load_fade = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/led_pwm_fade_ramp_unit.sv
`default_nettype none

// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    mode, channel, target_level, fade_time_ms
// rsp_ch   out  valid/ready    red_level, green_level, blue_level, fading_mask
// csr      in   csr_write_en   csr_index, csr_wdata (no read-back)
//
// One request at a time. A tick or a request with nothing to do goes from decode straight
// to response load. A fade goes through decode, 16 divider steps for time / interval,
// a handoff, 8 steps for range / divisions, ramp load and response load.
// Response sits in an output register; the next request is accepted while it waits and
// holds in its last cycle until the register frees. Reset is synchronous: all levels
// 255, no fades, all channels inverted, interval 75 ms.

module led_pwm_fade_ramp_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lpfr_req_if.sink                               req_ch,
   lpfr_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_write_en,
   input  wire logic [lpfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lpfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   lpfr_pkg::cmd_type cmd;
   lpfr_pkg::sts_type sts;

   lpfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpfr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_mode     (req_ch.mode),
      .req_channel  (req_ch.channel),
      .req_target   (req_ch.target_level),
      .req_time     (req_ch.fade_time_ms),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_red      (rsp_ch.red_level),
      .rsp_green    (rsp_ch.green_level),
      .rsp_blue     (rsp_ch.blue_level),
      .rsp_mask     (rsp_ch.fading_mask)
   );

endmodule

`default_nettype wire

>>> rtl/lpfr_checker.sv
`default_nettype none

module lpfr_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [lpfr_pkg::NUM_CH-1:0]     rsp_mask
);

   logic [1:0] open_ff, open_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) open_in = open_ff + 1'b1;
      if (!req_acc && rsp_acc) open_in = open_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while another is in work");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("response without an open request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mask))
      else $error("stalled response dropped or changed");

endmodule

bind led_pwm_fade_ramp_unit lpfr_checker u_lpfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_mask  (rsp_ch.fading_mask)
);

`default_nettype wire

>>> tb/lpfr_ramp_check.sv
`timescale 1ns / 1ps

module lpfr_ramp_check (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lpfr_req_if                                  req_ch,
   lpfr_rsp_if                                  rsp_ch,
   input  wire logic                            csr_write_en,
   input  wire logic [lpfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lpfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                          mismatch_count,
   output int unsigned                          pending_count
);

   typedef struct packed {
      logic [lpfr_pkg::LVL_W-1:0]  red;
      logic [lpfr_pkg::LVL_W-1:0]  green;
      logic [lpfr_pkg::LVL_W-1:0]  blue;
      logic [lpfr_pkg::NUM_CH-1:0] fading;
   } level_set_type;

   logic [lpfr_pkg::NUM_CH-1:0]         invert_mask;
   logic [lpfr_pkg::TIME_W-1:0]         step_interval;
   logic [lpfr_pkg::LVL_W-1:0]          level_now   [lpfr_pkg::NUM_CH];
   logic [lpfr_pkg::LVL_W-1:0]          final_level [lpfr_pkg::NUM_CH];
   logic signed [lpfr_pkg::DELTA_W-1:0] step_delta  [lpfr_pkg::NUM_CH];
   logic [lpfr_pkg::TIME_W-1:0]         steps_left  [lpfr_pkg::NUM_CH];

   level_set_type expected_levels[$];
   int unsigned   errors = 0;

   function automatic void start_ramp(int ch, int target, int dur);
      int iv;
      int divs;
      int cur;
      int span;
      int inc;
      logic inv;
      inv = invert_mask[ch];
      iv = (step_interval == 0) ? 1 : int'(step_interval);
      divs = (dur < iv) ? 1 : dur / iv;
      cur = level_now[ch];
      span = inv ? target - (255 - cur) : target - cur;
      if (span == 0) return;
      inc = span / divs;
      if (inv) inc = -inc;
      step_delta[ch] = inc[lpfr_pkg::DELTA_W-1:0];
      final_level[ch] = inv ? lpfr_pkg::LVL_W'(255 - target) : lpfr_pkg::LVL_W'(target);
      steps_left[ch] = lpfr_pkg::TIME_W'(dur / iv + ((dur % iv) != 0 ? 1 : 0));
   endfunction

   function automatic void advance_ramp(int ch);
      int cur;
      int fin;
      int d;
      int nxt;
      if (steps_left[ch] == 0) return;
      cur = level_now[ch];
      fin = final_level[ch];
      d = step_delta[ch];
      nxt = cur + d;
      if (d > 0 && nxt > fin) nxt = fin;
      if (d < 0 && nxt < fin) nxt = fin;
      steps_left[ch] = steps_left[ch] - 1'b1;
      if (steps_left[ch] == 0) nxt = fin;
      if (nxt < 0) nxt = 0;
      if (nxt > 255) nxt = 255;
      level_now[ch] = nxt[lpfr_pkg::LVL_W-1:0];
   endfunction

   function automatic void compare_field(string label, logic [lpfr_pkg::LVL_W-1:0] want,
                                         logic [lpfr_pkg::LVL_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t %s expected %0d got %0d", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      level_set_type want;
      level_set_type got;
      if (reset) begin
         invert_mask = lpfr_pkg::RESET_INVERT;
         step_interval = lpfr_pkg::RESET_INTERVAL;
         for (int c = 0; c < lpfr_pkg::NUM_CH; c++) begin
            level_now[c] = lpfr_pkg::FULL_LEVEL;
            final_level[c] = lpfr_pkg::FULL_LEVEL;
            step_delta[c] = '0;
            steps_left[c] = '0;
         end
         expected_levels.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               lpfr_pkg::CSR_INVERT_MASK:
                  invert_mask = csr_wdata[lpfr_pkg::NUM_CH-1:0];
               lpfr_pkg::CSR_STEP_INTVL:
                  step_interval = csr_wdata[lpfr_pkg::TIME_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.red_level, rsp_ch.green_level, rsp_ch.blue_level,
                    rsp_ch.fading_mask};
            if (expected_levels.size() == 0) begin
               errors++;
               $display("%0t unexpected response: expected none got %h", $time, got);
            end else begin
               want = expected_levels.pop_front();
               compare_field("red_level", want.red, got.red);
               compare_field("green_level", want.green, got.green);
               compare_field("blue_level", want.blue, got.blue);
               compare_field("fading_mask", lpfr_pkg::LVL_W'(want.fading),
                             lpfr_pkg::LVL_W'(got.fading));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == lpfr_pkg::MODE_FADE) begin
               if (req_ch.channel < lpfr_pkg::NUM_CH)
                  start_ramp(int'(req_ch.channel), int'(req_ch.target_level),
                             int'(req_ch.fade_time_ms));
            end else begin
               for (int c = 0; c < lpfr_pkg::NUM_CH; c++) advance_ramp(c);
            end
            want.red = level_now[0];
            want.green = level_now[1];
            want.blue = level_now[2];
            for (int c = 0; c < lpfr_pkg::NUM_CH; c++)
               want.fading[c] = (steps_left[c] != 0);
            expected_levels.push_back(want);
         end
      end
      pending_count <= expected_levels.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/led_pwm_fade_ramp_unit_test.sv
`timescale 1ns / 1ps

module led_pwm_fade_ramp_unit_test;

   localparam logic [lpfr_pkg::CH_W-1:0] CH_RED   = 2'd0;
   localparam logic [lpfr_pkg::CH_W-1:0] CH_GREEN = 2'd1;
   localparam logic [lpfr_pkg::CH_W-1:0] CH_BLUE  = 2'd2;
   localparam logic [lpfr_pkg::CH_W-1:0] CH_NONE  = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned PHASE_REQUESTS = 212;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [lpfr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lpfr_pkg::CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic [lpfr_pkg::TIME_W-1:0] cur_interval = lpfr_pkg::RESET_INTERVAL;

   lpfr_req_if req_ch();
   lpfr_rsp_if rsp_ch();

   led_pwm_fade_ramp_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   lpfr_ramp_check ramp_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("led_pwm_fade_ramp_unit verification failed");
         $finish;
      end
   end

   task automatic send_request(logic mode, logic [lpfr_pkg::CH_W-1:0] ch,
                               logic [lpfr_pkg::LVL_W-1:0] tgt,
                               logic [lpfr_pkg::TIME_W-1:0] dur);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.channel <= ch;
      req_ch.target_level <= tgt;
      req_ch.fade_time_ms <= dur;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_config(logic [lpfr_pkg::NUM_CH-1:0] mask,
                               logic [lpfr_pkg::TIME_W-1:0] interval);
      csr_write_en <= 1'b1;
      csr_index <= lpfr_pkg::CSR_INVERT_MASK;
      csr_wdata <= lpfr_pkg::CSR_DATA_W'(mask);
      @(posedge clock);
      csr_index <= lpfr_pkg::CSR_STEP_INTVL;
      csr_wdata <= interval;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_interval = interval;
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // mostly ticks, then ramps that finish within a handful of ticks, plus raw noise
   task automatic random_request;
      int unsigned pick;
      int unsigned iv;
      int unsigned dur;
      logic [lpfr_pkg::LVL_W-1:0] tgt;
      pick = $urandom_range(99);
      iv = (cur_interval == 0) ? 1 : cur_interval;
      if (pick < 55) begin
         send_request(lpfr_pkg::MODE_TICK, lpfr_pkg::CH_W'($urandom),
                      lpfr_pkg::LVL_W'($urandom), lpfr_pkg::TIME_W'($urandom));
      end else if (pick < 92) begin
         dur = $urandom_range(8) * iv + ($urandom_range(1) ? $urandom_range(iv - 1) : 0);
         if (dur > 65535) dur = 65535;
         case ($urandom_range(9))
            0:       tgt = 8'd0;
            1:       tgt = 8'd255;
            default: tgt = lpfr_pkg::LVL_W'($urandom);
         endcase
         send_request(lpfr_pkg::MODE_FADE, lpfr_pkg::CH_W'($urandom_range(2)), tgt,
                      lpfr_pkg::TIME_W'(dur));
      end else begin
         send_request(lpfr_pkg::MODE_FADE, lpfr_pkg::CH_W'($urandom),
                      lpfr_pkg::LVL_W'($urandom), lpfr_pkg::TIME_W'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = lpfr_pkg::MODE_FADE;
      req_ch.channel = CH_RED;
      req_ch.target_level = '0;
      req_ch.fade_time_ms = '0;
      csr_write_en = 1'b0;
      csr_index = lpfr_pkg::CSR_INVERT_MASK;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all channels inverted, 75 ms per tick
      send_request(lpfr_pkg::MODE_TICK, CH_RED, 8'd0, 16'd0);
      send_request(lpfr_pkg::MODE_FADE, CH_NONE, 8'd128, 16'd300);
      send_request(lpfr_pkg::MODE_FADE, CH_RED, 8'd0, 16'd300);
      send_request(lpfr_pkg::MODE_FADE, CH_RED, 8'd255, 16'd300);
      repeat (5) send_request(lpfr_pkg::MODE_TICK, CH_NONE, 8'd255, 16'hFFFF);
      send_request(lpfr_pkg::MODE_FADE, CH_GREEN, 8'd200, 16'd0);
      send_request(lpfr_pkg::MODE_TICK, CH_GREEN, 8'd0, 16'd0);
      send_request(lpfr_pkg::MODE_FADE, CH_BLUE, 8'd5, 16'd750);
      send_request(lpfr_pkg::MODE_FADE, CH_GREEN, 8'd255, 16'hFFFF);
      repeat (2) send_request(lpfr_pkg::MODE_TICK, CH_RED, 8'd0, 16'd0);
      send_request(lpfr_pkg::MODE_FADE, CH_GREEN, 8'd0, 16'd150);
      repeat (3) send_request(lpfr_pkg::MODE_TICK, CH_BLUE, 8'd0, 16'd0);
      send_request(lpfr_pkg::MODE_FADE, CH_RED, 8'd128, 16'd74);
      send_request(lpfr_pkg::MODE_FADE, CH_BLUE, 8'd255, 16'd76);
      repeat (2) send_request(lpfr_pkg::MODE_TICK, CH_RED, 8'd0, 16'd0);
      send_request(lpfr_pkg::MODE_FADE, CH_BLUE, 8'd0, 16'd1);
      send_request(lpfr_pkg::MODE_TICK, CH_RED, 8'd0, 16'd0);
      drain;

      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       write_config(3'b000, 16'd1);
            1:       write_config(3'b111, 16'hFFFF);
            2:       write_config(3'b101, 16'd0);
            3:       write_config(3'b010, 16'd75);
            4:       write_config(lpfr_pkg::NUM_CH'($urandom),
                                  lpfr_pkg::TIME_W'($urandom_range(1, 300)));
            5:       write_config(3'b011, 16'd10);
            6:       write_config(3'b110, 16'd4);
            default: write_config(lpfr_pkg::NUM_CH'($urandom), lpfr_pkg::TIME_W'($urandom));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         repeat (PHASE_REQUESTS) random_request();
         drain;
      end

      if (mismatch_count == 0)
         $display("led_pwm_fade_ramp_unit verification clean");
      else
         $display("led_pwm_fade_ramp_unit verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/lpfr_pkg.sv
rtl/lpfr_if.sv
rtl/lpfr_div.sv
rtl/lpfr_dp.sv
rtl/lpfr_ctrl.sv
rtl/led_pwm_fade_ramp_unit.sv
rtl/lpfr_checker.sv
tb/lpfr_ramp_check.sv
tb/led_pwm_fade_ramp_unit_test.sv
